@@ hw/rtl/y2r_pkg.sv @@
// Package for the YUV422 to RGB565 pair converter.
// Holds conversion constants, the inter-stage types and the clamp function.
// No dependencies.
`default_nettype none

package y2r_pkg;

    // chroma offset and fixed-point coefficients (scaled by 256)
    localparam logic signed [8:0]  ChromaBias = 9'sd128;
    localparam logic signed [15:0] KRv        = 16'sd103;
    localparam logic signed [15:0] KGu        = 16'sd88;
    localparam logic signed [15:0] KGv        = 16'sd183;
    localparam logic signed [15:0] KBu        = 16'sd198;
    localparam logic signed [10:0] ChanMax    = 11'sd255;

    // shared chroma terms of one word
    typedef struct packed {
        logic signed [9:0] tr;
        logic signed [9:0] tg;
        logic signed [9:0] tb;
    } y2r_terms_t;

    // word held between the chroma stage and the pixel lanes
    typedef struct packed {
        y2r_terms_t  terms;
        logic [7:0]  y0;
        logic [7:0]  y1;
        logic        last;
    } y2r_stage_t;

    // clamp a signed channel sum to 0..255
    function automatic logic [7:0] clamp8(input logic signed [10:0] x);
        logic [7:0] res;
        if (x < 11'sd0)
        begin
            res = 8'd0;
        end
        else if (x > ChanMax)
        begin
            res = 8'd255;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/y2r_in_if.sv @@
// Input channel of the converter: one packed YUV422 word per handshake.
// No dependencies.
`default_nettype none

interface y2r_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] yuv_word;
    logic        is_last;

    modport source (output valid, output yuv_word, output is_last, input ready);
    modport sink   (input valid, input yuv_word, input is_last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/y2r_out_if.sv @@
// Output channel of the converter: two RGB565 pixels per handshake.
// No dependencies.
`default_nettype none

interface y2r_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rgb_word;
    logic        last_out;

    modport source (output valid, output rgb_word, output last_out, input ready);
    modport sink   (input valid, input rgb_word, input last_out, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/y2r_chroma.sv @@
// Chroma stage: centers U/V, forms the three shared chroma terms and registers them
// together with both luma values. Depends on y2r_pkg and y2r_in_if.
`default_nettype none

module y2r_chroma (
    input  wire logic          clk,
    input  wire logic          rst_n,
    y2r_in_if.sink             pix_in,
    output y2r_pkg::y2r_stage_t st_data,
    output logic               st_valid,
    input  wire logic          st_ready
);
    import y2r_pkg::*;

    logic signed [8:0]  v_c;
    logic signed [8:0]  u_c;
    logic signed [15:0] p_rv;
    logic signed [15:0] p_gu;
    logic signed [15:0] p_gv;
    logic signed [15:0] p_bu;
    y2r_stage_t         st_next;
    y2r_stage_t         st_reg;
    logic               valid_reg;
    logic               take;

    // center chroma and multiply by constants
    assign v_c  = $signed({1'b0, pix_in.yuv_word[31:24]}) - ChromaBias;
    assign u_c  = $signed({1'b0, pix_in.yuv_word[15:8]}) - ChromaBias;
    assign p_rv = 16'(v_c) * KRv;
    assign p_gu = 16'(u_c) * KGu;
    assign p_gv = 16'(v_c) * KGv;
    assign p_bu = 16'(u_c) * KBu;

    // upper byte of each product is the floored quotient by 256
    always_comb
    begin
        st_next.terms.tr = 10'(v_c) + 10'($signed(p_rv[15:8]));
        st_next.terms.tg = 10'($signed(p_gu[15:8])) + 10'($signed(p_gv[15:8]));
        st_next.terms.tb = 10'(u_c) + 10'($signed(p_bu[15:8]));
        st_next.y0       = pix_in.yuv_word[23:16];
        st_next.y1       = pix_in.yuv_word[7:0];
        st_next.last     = pix_in.is_last;
    end

    // stage accepts when empty or when its word leaves this cycle
    assign pix_in.ready = !valid_reg || st_ready;
    assign take         = pix_in.valid && pix_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            valid_reg <= pix_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            st_reg <= st_next;
        end
    end

    assign st_data  = st_reg;
    assign st_valid = valid_reg;

endmodule

`default_nettype wire

@@ hw/rtl/y2r_lane.sv @@
// Pixel lane: adds the shared chroma terms to one luma, clamps and packs RGB565.
// Depends on y2r_pkg.
`default_nettype none

module y2r_lane (
    input  wire logic [7:0]         luma,
    input  wire y2r_pkg::y2r_terms_t terms,
    output logic [15:0]             pix565
);
    import y2r_pkg::*;

    logic signed [10:0] y_s;
    logic signed [10:0] r_sum;
    logic signed [10:0] g_sum;
    logic signed [10:0] b_sum;
    logic [7:0]         r8;
    logic [7:0]         g8;
    logic [7:0]         b8;

    // channel sums
    assign y_s   = $signed({3'b000, luma});
    assign r_sum = y_s + 11'(terms.tr);
    assign g_sum = y_s - 11'(terms.tg);
    assign b_sum = y_s + 11'(terms.tb);

    // saturate and truncate to 5/6/5
    assign r8     = clamp8(r_sum);
    assign g8     = clamp8(g_sum);
    assign b8     = clamp8(b_sum);
    assign pix565 = {r8[7:3], g8[7:2], b8[7:3]};

endmodule

`default_nettype wire

@@ hw/rtl/yuv422_to_rgb565_pair.sv @@
// Top level of the YUV422 to RGB565 pair converter.
// Depends on y2r_pkg, y2r_in_if, y2r_out_if, y2r_chroma and y2r_lane.
`default_nettype none

// Converts one packed YUV422 word (V, Y0, U, Y1 from the top byte down) into two
// RGB565 pixels, Y0's pixel in the upper half of the output word. The chroma
// stage registers the three shared terms, then two pixel lanes run in parallel
// into the output register. Backpressure stalls the pipeline; with the output
// ready held high the throughput is one word every cycle. The last flag travels
// with its word unchanged. There is no configuration and no reset-time fill.
module yuv422_to_rgb565_pair (
    input  wire logic clk,
    input  wire logic rst_n,
    y2r_in_if.sink    pix_in,
    y2r_out_if.source pix_out
);
    import y2r_pkg::*;

    y2r_stage_t  st_data;
    logic        st_valid;
    logic        st_ready;
    logic [15:0] pix_hi;
    logic [15:0] pix_lo;
    logic [31:0] rgb_next;
    logic [31:0] rgb_reg;
    logic        last_reg;
    logic        out_valid_reg;

    // shared chroma stage
    y2r_chroma u_chroma (
        .clk      (clk),
        .rst_n    (rst_n),
        .pix_in   (pix_in),
        .st_data  (st_data),
        .st_valid (st_valid),
        .st_ready (st_ready)
    );

    // one lane per pixel
    y2r_lane u_lane_hi (
        .luma   (st_data.y0),
        .terms  (st_data.terms),
        .pix565 (pix_hi)
    );

    y2r_lane u_lane_lo (
        .luma   (st_data.y1),
        .terms  (st_data.terms),
        .pix565 (pix_lo)
    );

    // merge lanes into the output word
    assign rgb_next = {pix_hi, pix_lo};
    assign st_ready = !out_valid_reg || pix_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (st_ready)
        begin
            out_valid_reg <= st_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_ready && st_valid)
        begin
            rgb_reg  <= rgb_next;
            last_reg <= st_data.last;
        end
    end

    assign pix_out.valid    = out_valid_reg;
    assign pix_out.rgb_word = rgb_reg;
    assign pix_out.last_out = last_reg;

endmodule

`default_nettype wire
